@@ design/rmq_pkg.sv @@
// ---------------------------------------------------------------------------
// rmq_pkg
// Shared widths, slot codes and pipeline stage types for the rotation
// matrix to quaternion converter.
// ---------------------------------------------------------------------------
`default_nettype none

package rmq_pkg;

  // word format
  localparam int DW = 16;                    // element and result width
  localparam int FB = 14;                    // fraction bits

  // derived widths
  localparam int TW       = DW + 3;          // trace and sqrt argument, signed
  localparam int AW       = DW + 1;          // clamped sqrt argument, unsigned
  localparam int NW       = AW + FB;         // radicand
  localparam int SQ_STEPS = (NW + 1) / 2;    // one root bit per stage
  localparam int NPW      = 2 * SQ_STEPS;    // radicand padded to whole digit pairs
  localparam int RW       = SQ_STEPS;        // root width
  localparam int SRW      = RW + 2;          // sqrt partial remainder
  localparam int DFW      = DW + 1;          // element difference or sum
  localparam int DVW      = DW + FB + 1;     // dividend
  localparam int DRW      = RW + 1;          // divisor, twice the root
  localparam int QW       = DW + FB - FB / 2;// quotient bits
  localparam int LATENCY  = SQ_STEPS + QW + 3;

  localparam logic [DW-1:0] QMAX = {1'b0, {(DW-1){1'b1}}};
  localparam logic [DW-1:0] QMIN = {1'b1, {(DW-1){1'b0}}};

  // quaternion part that takes the root
  typedef enum logic [1:0] {
    SLOT_W = 2'd0,
    SLOT_X = 2'd1,
    SLOT_Y = 2'd2,
    SLOT_Z = 2'd3
  } slot_t;

  // square root stage
  typedef struct packed {
    logic                   valid;
    slot_t                  slot;
    logic                   degen;
    logic [RW-1:0]          root;
    logic [SRW-1:0]         rem;
    logic [NPW-1:0]         n;
    logic [2:0][DFW-1:0]    d;
  } sq_t;

  // divider stage
  typedef struct packed {
    logic                   valid;
    slot_t                  slot;
    logic                   degen;
    logic [RW-1:0]          root;
    logic [DRW-1:0]         div;
    logic [2:0]             neg;
    logic [2:0][DRW-1:0]    rem;
    logic [2:0][QW-1:0]     low;
  } dv_t;

endpackage

`default_nettype wire

@@ design/rotation_matrix_to_quaternion.sv @@
// ---------------------------------------------------------------------------
// rotation_matrix_to_quaternion
// Converts a 3x3 rotation matrix in signed Q2.14 to a unit quaternion with
// a pipelined square root and three pipelined dividers.
//
//   channel   signals                          direction
//   matrix    start, busy, m00 .. m22          in
//   quat      done, quat_w .. quat_z,          out
//             degenerate
//
// One word enters every cycle; busy stays low.
// Pipeline: one front stage, 16 square root stages (one root bit each),
// one divider setup stage, 23 divider stages (one quotient bit each) and
// one output register.
// Reset clears the valid bits of every stage; words in flight are dropped.
// The receiver cannot stall, so the pipeline never holds.
// ---------------------------------------------------------------------------
`default_nettype none

module rotation_matrix_to_quaternion (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      start,
  output logic                           busy,
  input  wire logic signed [rmq_pkg::DW-1:0] m00,
  input  wire logic signed [rmq_pkg::DW-1:0] m01,
  input  wire logic signed [rmq_pkg::DW-1:0] m02,
  input  wire logic signed [rmq_pkg::DW-1:0] m10,
  input  wire logic signed [rmq_pkg::DW-1:0] m11,
  input  wire logic signed [rmq_pkg::DW-1:0] m12,
  input  wire logic signed [rmq_pkg::DW-1:0] m20,
  input  wire logic signed [rmq_pkg::DW-1:0] m21,
  input  wire logic signed [rmq_pkg::DW-1:0] m22,
  output logic                           done,
  output logic signed [rmq_pkg::DW-1:0]  quat_w,
  output logic signed [rmq_pkg::DW-1:0]  quat_x,
  output logic signed [rmq_pkg::DW-1:0]  quat_y,
  output logic signed [rmq_pkg::DW-1:0]  quat_z,
  output logic                           degenerate
);

  localparam int DW  = rmq_pkg::DW;
  localparam int FB  = rmq_pkg::FB;
  localparam int TW  = rmq_pkg::TW;
  localparam int AW  = rmq_pkg::AW;
  localparam int NPW = rmq_pkg::NPW;
  localparam int RW  = rmq_pkg::RW;
  localparam int SRW = rmq_pkg::SRW;
  localparam int DFW = rmq_pkg::DFW;
  localparam int DVW = rmq_pkg::DVW;
  localparam int DRW = rmq_pkg::DRW;
  localparam int QW  = rmq_pkg::QW;
  localparam int SQS = rmq_pkg::SQ_STEPS;

  rmq_pkg::sq_t sq      [SQS+1];
  rmq_pkg::sq_t sq_next [SQS+1];
  rmq_pkg::dv_t dv      [QW+1];
  rmq_pkg::dv_t dv_next [QW+1];
  rmq_pkg::sq_t sq_head;
  rmq_pkg::dv_t dv_head;

  assign busy = 1'b0;

  // front end: trace, branch choice, sqrt argument and the three numerators
  logic signed [TW-1:0]  t00, t11, t22, trace, arg, one_t;
  logic [1:0]            diag;
  logic                  pos, degen0;
  logic [AW-1:0]         arg_use;

  always_comb begin
    t00   = TW'(m00);
    t11   = TW'(m11);
    t22   = TW'(m22);
    one_t = TW'(1) <<< FB;
    trace = t00 + t11 + t22;
    pos   = trace > TW'(0);
    diag  = 2'd0;
    if (m11 > m00) diag = 2'd1;
    if ((diag == 2'd1) ? (m22 > m11) : (m22 > m00)) diag = 2'd2;

    sq_head       = '0;
    sq_head.valid = start;
    arg           = trace + one_t;
    if (pos) begin
      sq_head.slot = rmq_pkg::SLOT_W;
      sq_head.d[0] = DFW'(m21) - DFW'(m12);
      sq_head.d[1] = DFW'(m02) - DFW'(m20);
      sq_head.d[2] = DFW'(m10) - DFW'(m01);
    end else begin
      unique case (diag)
        2'd0: begin
          arg          = t00 - t11 - t22 + one_t;
          sq_head.slot = rmq_pkg::SLOT_X;
          sq_head.d[0] = DFW'(m21) - DFW'(m12);
          sq_head.d[1] = DFW'(m10) + DFW'(m01);
          sq_head.d[2] = DFW'(m20) + DFW'(m02);
        end
        2'd1: begin
          arg          = t11 - t22 - t00 + one_t;
          sq_head.slot = rmq_pkg::SLOT_Y;
          sq_head.d[0] = DFW'(m02) - DFW'(m20);
          sq_head.d[1] = DFW'(m01) + DFW'(m10);
          sq_head.d[2] = DFW'(m21) + DFW'(m12);
        end
        default: begin
          arg          = t22 - t00 - t11 + one_t;
          sq_head.slot = rmq_pkg::SLOT_Z;
          sq_head.d[0] = DFW'(m10) - DFW'(m01);
          sq_head.d[1] = DFW'(m20) + DFW'(m02);
          sq_head.d[2] = DFW'(m12) + DFW'(m21);
        end
      endcase
    end
    // non-positive argument: clamp to one code so the root stays nonzero
    degen0        = !pos && (arg <= TW'(0));
    arg_use       = degen0 ? AW'(1) : arg[AW-1:0];
    sq_head.degen = degen0;
    sq_head.n     = NPW'({arg_use, {FB{1'b0}}});
  end

  // square root, one root bit per stage
  logic [SRW+1:0] sq_r2  [SQS];
  logic [SRW+1:0] sq_try [SQS];

  always_comb begin
    sq_next[0] = sq_head;
    for (int k = 0; k < SQS; k++) begin
      sq_next[k+1]      = sq[k];
      sq_r2[k]          = {sq[k].rem, sq[k].n[NPW-1 -: 2]};
      sq_try[k]         = (SRW+2)'({sq[k].root, 2'b01});
      sq_next[k+1].n    = sq[k].n << 2;
      if (sq_r2[k] >= sq_try[k]) begin
        sq_next[k+1].rem  = SRW'(sq_r2[k] - sq_try[k]);
        sq_next[k+1].root = {sq[k].root[RW-2:0], 1'b1};
      end else begin
        sq_next[k+1].rem  = SRW'(sq_r2[k]);
        sq_next[k+1].root = {sq[k].root[RW-2:0], 1'b0};
      end
    end
  end

  // divider setup: magnitude times one, plus root for rounding, over 2 root
  logic [DFW-1:0] mag      [3];
  logic [DVW-1:0] dividend [3];

  always_comb begin
    dv_head       = '0;
    dv_head.valid = sq[SQS].valid;
    dv_head.slot  = sq[SQS].slot;
    dv_head.degen = sq[SQS].degen;
    dv_head.root  = sq[SQS].root;
    dv_head.div   = {sq[SQS].root, 1'b0};
    for (int j = 0; j < 3; j++) begin
      dv_head.neg[j] = sq[SQS].d[j][DFW-1];
      mag[j]         = sq[SQS].d[j][DFW-1] ? (DFW'(0) - sq[SQS].d[j]) : sq[SQS].d[j];
      dividend[j]    = DVW'({mag[j], {FB{1'b0}}}) + DVW'(sq[SQS].root);
      dv_head.rem[j] = DRW'(dividend[j][DVW-1:QW]);
      dv_head.low[j] = dividend[j][QW-1:0];
    end
  end

  // restoring division, one quotient bit per stage in each of three lanes
  logic [DRW:0] dv_r2 [QW][3];

  always_comb begin
    dv_next[0] = dv_head;
    for (int k = 0; k < QW; k++) begin
      dv_next[k+1] = dv[k];
      for (int j = 0; j < 3; j++) begin
        dv_r2[k][j] = {dv[k].rem[j], dv[k].low[j][QW-1]};
        if (dv_r2[k][j] >= {1'b0, dv[k].div}) begin
          dv_next[k+1].rem[j] = DRW'(dv_r2[k][j] - {1'b0, dv[k].div});
          dv_next[k+1].low[j] = {dv[k].low[j][QW-2:0], 1'b1};
        end else begin
          dv_next[k+1].rem[j] = DRW'(dv_r2[k][j]);
          dv_next[k+1].low[j] = {dv[k].low[j][QW-2:0], 1'b0};
        end
      end
    end
  end

  // sign, saturation and placement of the four parts
  logic [RW:0]    rsum;
  logic [DW-1:0]  rpart;
  logic [DW-1:0]  lane [3];
  logic [DW-1:0]  part [4];

  always_comb begin
    rsum  = {1'b0, dv[QW].root} + (RW+1)'(1);
    rpart = DW'(rsum[RW:1]);
    for (int j = 0; j < 3; j++) begin
      if (!dv[QW].neg[j]) begin
        lane[j] = (dv[QW].low[j] > QW'(rmq_pkg::QMAX)) ? rmq_pkg::QMAX
                                                        : DW'(dv[QW].low[j]);
      end else begin
        lane[j] = (dv[QW].low[j] > QW'(rmq_pkg::QMIN)) ? rmq_pkg::QMIN
                                                        : DW'(QW'(0) - dv[QW].low[j]);
      end
    end
    for (int s = 0; s < 4; s++) begin
      if (dv[QW].degen) begin
        part[s] = '0;
      end else if (2'(s) == dv[QW].slot) begin
        part[s] = rpart;
      end else if (2'(s) < dv[QW].slot) begin
        part[s] = lane[(s < 3) ? s : 2];
      end else begin
        part[s] = lane[(s > 0) ? s - 1 : 0];
      end
    end
  end

  // stage registers, valid bits cleared by reset
  always_ff @(posedge clk) begin
    quat_w <= part[0];
    quat_x <= part[1];
    quat_y <= part[2];
    quat_z <= part[3];
    if (rst) begin
      for (int k = 0; k <= SQS; k++) sq[k].valid <= 1'b0;
      for (int k = 0; k <= QW; k++)  dv[k].valid <= 1'b0;
      done       <= 1'b0;
      degenerate <= 1'b0;
    end else begin
      for (int k = 0; k <= SQS; k++) sq[k] <= sq_next[k];
      for (int k = 0; k <= QW; k++)  dv[k] <= dv_next[k];
      done       <= dv[QW].valid;
      degenerate <= dv[QW].valid & dv[QW].degen;
    end
  end

endmodule

`default_nettype wire

@@ design/rmq_check.sv @@
// ---------------------------------------------------------------------------
// rmq_check
// Port-level checks for the rotation matrix to quaternion converter.
// ---------------------------------------------------------------------------
`default_nettype none

module rmq_check (
  input wire logic                          clk,
  input wire logic                          rst,
  input wire logic                          start,
  input wire logic                          busy,
  input wire logic                          done,
  input wire logic signed [rmq_pkg::DW-1:0] quat_w,
  input wire logic signed [rmq_pkg::DW-1:0] quat_x,
  input wire logic signed [rmq_pkg::DW-1:0] quat_y,
  input wire logic signed [rmq_pkg::DW-1:0] quat_z,
  input wire logic                          degenerate
);

  localparam int CW = $clog2(rmq_pkg::LATENCY + 1);

  logic [CW-1:0] age;

  // cycles since reset, saturating at the pipeline latency
  always_ff @(posedge clk) begin
    if (rst) begin
      age <= '0;
    end else if (age != CW'(rmq_pkg::LATENCY)) begin
      age <= age + CW'(1);
    end
  end

  // every accepted word comes out a fixed latency later
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (age == CW'(rmq_pkg::LATENCY)) |-> (done == $past(start && !busy, rmq_pkg::LATENCY)))
    else $error("done does not match accepted word");

  // a degenerate word carries a zero quaternion
  a_degen_zero: assert property (@(posedge clk) disable iff (rst)
    (done && degenerate) |-> (quat_w == '0 && quat_x == '0 && quat_y == '0 && quat_z == '0))
    else $error("degenerate word with nonzero quaternion");

  // flag only with a result
  a_degen_done: assert property (@(posedge clk) disable iff (rst)
    degenerate |-> done)
    else $error("degenerate without done");

  // input side never stalls
  a_no_busy: assert property (@(posedge clk) disable iff (rst)
    !busy)
    else $error("busy raised");

endmodule

bind rotation_matrix_to_quaternion rmq_check u_rmq_check (
  .clk(clk), .rst(rst), .start(start), .busy(busy), .done(done),
  .quat_w(quat_w), .quat_x(quat_x), .quat_y(quat_y), .quat_z(quat_z),
  .degenerate(degenerate)
);

`default_nettype wire

@@ test/tb_rotation_matrix_to_quaternion.sv @@
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_rotation_matrix_to_quaternion
// Drives matrices into the converter with random gaps, predicts each
// quaternion with a bit-exact integer model and checks every output word
// in order against the predictions.
// ---------------------------------------------------------------------------

// quaternion expected for one matrix word
typedef struct {
  logic signed [15:0] w, x, y, z;
  logic               degen;
} quat_word_t;

class quat_scoreboard;
  quat_word_t pending[$];
  int         errors;

  function new();
    errors = 0;
  endfunction

  // integer square root, floor
  static function longint unsigned int_sqrt(longint unsigned n);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv >>= 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  // d * 2^14 / (2 r), magnitude rounded half up, sign of d
  static function longint ratio(longint d, longint unsigned r);
    longint unsigned mag, q;
    mag = d < 0 ? -d : d;
    q = ((mag << 14) + r) / (r << 1);
    return d < 0 ? -longint'(q) : longint'(q);
  endfunction

  static function logic signed [15:0] sat16(longint v);
    if (v > 32767) return 16'sh7fff;
    if (v < -32768) return 16'sh8000;
    return v[15:0];
  endfunction

  // predict the quaternion for one matrix
  function void note_matrix(logic signed [15:0] e[9]);
    longint m[3][3];
    longint q[4];
    longint tr, a;
    longint unsigned rt;
    int i, j, k;
    quat_word_t res;
    foreach (e[n]) m[n / 3][n % 3] = e[n];
    q = '{0, 0, 0, 0};
    res.degen = 1'b0;
    tr = m[0][0] + m[1][1] + m[2][2];
    if (tr > 0) begin
      rt = int_sqrt((tr + 16384) << 14);
      q[0] = (rt + 1) >> 1;
      q[1] = ratio(m[2][1] - m[1][2], rt);
      q[2] = ratio(m[0][2] - m[2][0], rt);
      q[3] = ratio(m[1][0] - m[0][1], rt);
    end else begin
      i = 0;
      if (m[1][1] > m[0][0]) i = 1;
      if (m[2][2] > m[i][i]) i = 2;
      j = (i + 1) % 3;
      k = (j + 1) % 3;
      a = m[i][i] - m[j][j] - m[k][k] + 16384;
      if (a <= 0) begin
        res.degen = 1'b1;
      end else begin
        rt = int_sqrt(a << 14);
        q[1 + i] = (rt + 1) >> 1;
        q[0] = ratio(m[k][j] - m[j][k], rt);
        q[1 + j] = ratio(m[j][i] + m[i][j], rt);
        q[1 + k] = ratio(m[k][i] + m[i][k], rt);
      end
    end
    res.w = sat16(q[0]);
    res.x = sat16(q[1]);
    res.y = sat16(q[2]);
    res.z = sat16(q[3]);
    pending.push_back(res);
  endfunction

  function void check_quat(quat_word_t got);
    quat_word_t exp_q;
    if (pending.size() == 0) begin
      $display("%0t: unexpected word w=%0d x=%0d y=%0d z=%0d deg=%0b",
               $time, got.w, got.x, got.y, got.z, got.degen);
      errors++;
      return;
    end
    exp_q = pending.pop_front();
    if (got.w !== exp_q.w || got.x !== exp_q.x || got.y !== exp_q.y ||
        got.z !== exp_q.z || got.degen !== exp_q.degen) begin
      $display("%0t: mismatch expected w=%0d x=%0d y=%0d z=%0d deg=%0b",
               $time, exp_q.w, exp_q.x, exp_q.y, exp_q.z, exp_q.degen);
      $display("%0t:          actual   w=%0d x=%0d y=%0d z=%0d deg=%0b",
               $time, got.w, got.x, got.y, got.z, got.degen);
      errors++;
    end
  endfunction
endclass

module tb_rotation_matrix_to_quaternion;
  logic clk = 0;
  logic rst = 1;
  logic start = 0;
  logic busy, done, degenerate;
  logic signed [15:0] m00 = 0, m01 = 0, m02 = 0, m10 = 0, m11 = 0;
  logic signed [15:0] m12 = 0, m20 = 0, m21 = 0, m22 = 0;
  logic signed [15:0] quat_w, quat_x, quat_y, quat_z;
  quat_scoreboard sb;

  rotation_matrix_to_quaternion dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .m00(m00), .m01(m01), .m02(m02), .m10(m10), .m11(m11), .m12(m12),
    .m20(m20), .m21(m21), .m22(m22),
    .done(done), .quat_w(quat_w), .quat_x(quat_x), .quat_y(quat_y),
    .quat_z(quat_z), .degenerate(degenerate)
  );

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  // output monitor
  always @(posedge clk) begin
    quat_word_t got;
    if (!rst && done) begin
      got.w = quat_w;
      got.x = quat_x;
      got.y = quat_y;
      got.z = quat_z;
      got.degen = degenerate;
      sb.check_quat(got);
    end
  end

  // present one matrix word, hold until accepted, then optional gap
  task automatic send_matrix(logic signed [15:0] e[9], int gap);
    start <= 1'b1;
    m00 <= e[0]; m01 <= e[1]; m02 <= e[2];
    m10 <= e[3]; m11 <= e[4]; m12 <= e[5];
    m20 <= e[6]; m21 <= e[7]; m22 <= e[8];
    do @(posedge clk); while (busy);
    sb.note_matrix(e);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // random element near a scaled value
  function automatic logic signed [15:0] near(int v, int spread);
    int r;
    r = v + $urandom_range(2 * spread) - spread;
    if (r > 32767) r = 32767;
    if (r < -32768) r = -32768;
    return r[15:0];
  endfunction

  // well-formed rotation matrix from a random quaternion, with jitter
  function automatic void rand_rotation(output logic signed [15:0] e[9], input int jit);
    real qw, qx, qy, qz, nrm;
    real rm[9];
    qw = $urandom_range(2000) - 1000.0;
    qx = $urandom_range(2000) - 1000.0;
    qy = $urandom_range(2000) - 1000.0;
    qz = $urandom_range(2000) - 1000.0;
    nrm = $sqrt(qw*qw + qx*qx + qy*qy + qz*qz) + 1.0e-9;
    qw /= nrm; qx /= nrm; qy /= nrm; qz /= nrm;
    rm[0] = 1 - 2*(qy*qy + qz*qz); rm[1] = 2*(qx*qy - qz*qw); rm[2] = 2*(qx*qz + qy*qw);
    rm[3] = 2*(qx*qy + qz*qw); rm[4] = 1 - 2*(qx*qx + qz*qz); rm[5] = 2*(qy*qz - qx*qw);
    rm[6] = 2*(qx*qz - qy*qw); rm[7] = 2*(qy*qz + qx*qw); rm[8] = 1 - 2*(qx*qx + qy*qy);
    foreach (e[n]) e[n] = near($rtoi(rm[n] * 16384.0), jit);
  endfunction

  initial begin
    logic signed [15:0] e[9];
    int kind;
    sb = new();
    repeat (3) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: identity, axis flips, extremes, zero trace
    send_matrix('{16384, 0, 0, 0, 16384, 0, 0, 0, 16384}, 0);
    send_matrix('{16384, 0, 0, 0, -16384, 0, 0, 0, -16384}, 1);
    send_matrix('{-16384, 0, 0, 0, 16384, 0, 0, 0, -16384}, 0);
    send_matrix('{-16384, 0, 0, 0, -16384, 0, 0, 0, 16384}, 2);
    send_matrix('{0, -16384, 0, 16384, 0, 0, 0, 0, 16384}, 0);
    send_matrix('{0, 0, 0, 0, 0, 0, 0, 0, 0}, 0);
    send_matrix('{100, 5, 7, 9, -100, 3, 1, 2, 0}, 0);
    send_matrix('{-16384, 0, 0, 0, -16384, 0, 0, 0, -16384}, 3);
    send_matrix('{-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768,
                  -32768}, 0);
    send_matrix('{32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767}, 0);
    send_matrix('{32767, -32768, 32767, -32768, 32767, -32768, 32767, -32768, 32767}, 0);
    send_matrix('{1, 32767, -32768, -32768, 1, 32767, 32767, -32768, 1}, 1);
    send_matrix('{-32768, 32767, 32767, 32767, -32768, 32767, 32767, 32767, 32767}, 0);
    send_matrix('{5000, 32767, -32768, -32768, 5000, 32767, 32767, -32768, 5000}, 0);
    send_matrix('{-5, 32767, 32767, -32768, -5, -32768, 32767, 32767, -5}, 0);
    send_matrix('{0, 1, 2, 3, 0, 4, 5, 6, 0}, 0);
    send_matrix('{-1, 0, 0, 0, -1, 0, 0, 0, -1}, 0);

    // random: mostly rotations, some noisy, some fully random, some ties
    repeat (850) begin
      kind = $urandom_range(9);
      if (kind < 5) begin
        rand_rotation(e, 0);
      end else if (kind < 7) begin
        rand_rotation(e, 600);
      end else if (kind < 9) begin
        foreach (e[n]) e[n] = 16'($urandom());
      end else begin
        foreach (e[n]) e[n] = near(0, 64);
        e[4] = e[0];
        if ($urandom_range(1)) e[8] = e[0];
      end
      send_matrix(e, $urandom_range(3) == 0 ? 0 : $urandom_range(5));
    end
    start <= 1'b0;

    // drain
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (sb.errors == 0)
      $display("tb_rotation_matrix_to_quaternion OK");
    else
      $display("tb_rotation_matrix_to_quaternion NOT OK");
    $finish;
  end

  // watchdog
  initial begin
    #2000000;
    $display("tb_rotation_matrix_to_quaternion NOT OK");
    $finish;
  end
endmodule
